// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the cache lookup checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define SACN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SACN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sacn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacn_pkg
// Types and constants shared by the set-associative NRU cache lookup block.
// ----------------------------------------------------------------------------
package sacn_pkg;

    localparam int ADDR_W     = 32;
    localparam int RAW_SET_W  = 15;
    localparam int OUT_WAY_W  = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS  = 2'd1;
    localparam logic [1:0] REG_INDEX_BITS   = 2'd2;
    localparam logic [1:0] REG_WAYS_IN_USE  = 2'd3;

    localparam logic [5:0] RST_ADDRESS_BITS = 6'd32;
    localparam logic [4:0] RST_OFFSET_BITS  = 5'd4;
    localparam logic [3:0] RST_INDEX_BITS   = 4'd8;
    localparam logic [3:0] RST_WAYS_IN_USE  = 4'd8;

    typedef struct packed {
        logic [5:0] address_bits;
        logic [4:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_MOD,
        S_ROW,
        S_CMP,
        S_WB
    } state_t;

endpackage

// ===== sv/sacn_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacn_cfg_regs
// APB register file holding the address split and associativity settings.
// ----------------------------------------------------------------------------
module sacn_cfg_regs
    import sacn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_bits <= RST_ADDRESS_BITS;
            cfg_reg.offset_bits  <= RST_OFFSET_BITS;
            cfg_reg.index_bits   <= RST_INDEX_BITS;
            cfg_reg.ways_in_use  <= RST_WAYS_IN_USE;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ADDRESS_BITS: cfg_reg.address_bits <= pwdata[5:0];
                REG_OFFSET_BITS:  cfg_reg.offset_bits  <= pwdata[4:0];
                REG_INDEX_BITS:   cfg_reg.index_bits   <= pwdata[3:0];
                REG_WAYS_IN_USE:  cfg_reg.ways_in_use  <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ADDRESS_BITS: prdata = APB_DATA_W'(cfg_reg.address_bits);
            REG_OFFSET_BITS:  prdata = APB_DATA_W'(cfg_reg.offset_bits);
            REG_INDEX_BITS:   prdata = APB_DATA_W'(cfg_reg.index_bits);
            REG_WAYS_IN_USE:  prdata = APB_DATA_W'(cfg_reg.ways_in_use);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== sv/sacn_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacn_engine
// Sequenced tag search: one tag comparator walks the ways of a set.
// ----------------------------------------------------------------------------
module sacn_engine
    import sacn_pkg::*;
#(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 256,
    parameter int TAG_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 is_hit,
    output logic [OUT_WAY_W-1:0] way
);

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
    localparam int TADDR_W   = SET_W + WAY_W;
    localparam int TDEPTH    = 1 << TADDR_W;
    localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(MAX_SETS - 1);

    // Reciprocal of MAX_SETS, exact for every raw set index of RAW_SET_W bits.
    localparam int RECIP_SH  = RAW_SET_W + SET_W;
    localparam int RECIP_W   = RAW_SET_W + 2;
    localparam int PROD_W    = RAW_SET_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + MAX_SETS - 1) / MAX_SETS);
    localparam logic [RAW_SET_W-1:0] SETS_DIV = RAW_SET_W'(MAX_SETS);

    // Storage: tags per (set, way); valid and NRU bits as one row per set.
    logic [TAG_WIDTH-1:0] tag_mem   [TDEPTH];
    logic [MAX_WAYS-1:0]  valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]  nru_mem   [MAX_SETS];

    state_t                state_reg, state_next;
    logic [SET_W-1:0]      clr_reg;
    logic                  step_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  nru_found_reg;
    logic [WAY_W-1:0]      nru_way_reg;
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [WAY_W-1:0]      out_way_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [TAG_WIDTH-1:0]  tag_reg;
    logic [RAW_SET_W-1:0]  rem_reg;
    logic [RAW_SET_W-1:0]  quo_reg;
    logic [TAG_WIDTH-1:0]  tag_rd_reg;
    logic [MAX_WAYS-1:0]   valid_row_reg;
    logic [MAX_WAYS-1:0]   nru_row_reg;
    logic                  res_hit_reg;
    logic [WAY_W-1:0]      res_way_reg;
    logic                  refill_reg;

    logic [5:0]            abits_eff;
    logic [ADDR_W-1:0]     addr_mask;
    logic [ADDR_W-1:0]     addr_m;
    logic [5:0]            tag_sh;
    logic [ADDR_W-1:0]     tag_full;
    logic [ADDR_W-1:0]     set_sh;
    logic [15:0]           idx_mask;
    logic [RAW_SET_W-1:0]  raw_set;
    logic [WCNT_W-1:0]     ways_eff;
    logic [PROD_W-1:0]     mod_prod;
    logic [RAW_SET_W-1:0]  mod_quo;
    logic [RAW_SET_W-1:0]  mod_back;
    logic [SET_W-1:0]      set_sel;
    logic                  way_hit;
    logic                  way_last;
    logic                  nru_here;
    logic                  vic_found;
    logic [WAY_W-1:0]      vic_way;
    logic [MAX_WAYS-1:0]   ways_mask;
    logic [MAX_WAYS-1:0]   res_onehot;
    logic [MAX_WAYS-1:0]   nru_base;
    logic [MAX_WAYS-1:0]   nru_wb;
    logic [MAX_WAYS-1:0]   valid_wb;
    logic [WAY_W-1:0]      tag_rd_way;
    logic [SET_W-1:0]      row_waddr;
    logic [ADDR_W-1:0]     out_way_ext;

    logic                  wb_go;
    logic                  row_we;
    logic                  tag_we;
    logic                  clearing;

    // Effective configuration and address split.
    always_comb
    begin
        if (cfg.address_bits == 6'd0)
            abits_eff = 6'd1;
        else if (cfg.address_bits > 6'd32)
            abits_eff = 6'd32;
        else
            abits_eff = cfg.address_bits;

        if (cfg.ways_in_use == 4'd0)
            ways_eff = WCNT_W'(1);
        else if (32'(cfg.ways_in_use) > MAX_WAYS)
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = WCNT_W'(cfg.ways_in_use);
    end

    assign addr_mask = (abits_eff >= 6'd32) ? '1 : ((ADDR_W'(1) << abits_eff) - ADDR_W'(1));
    assign addr_m    = addr_reg & addr_mask;
    assign tag_sh    = {1'b0, cfg.offset_bits} + {2'b00, cfg.index_bits};
    assign tag_full  = (tag_sh >= 6'd32) ? '0 : (addr_m >> tag_sh[4:0]);
    assign set_sh    = addr_m >> cfg.offset_bits;
    assign idx_mask  = (16'd1 << cfg.index_bits) - 16'd1;
    assign raw_set   = set_sh[RAW_SET_W-1:0] & idx_mask[RAW_SET_W-1:0];

    // Reduction of the raw set index modulo MAX_SETS by a reciprocal multiply:
    // the first step forms the quotient, the second subtracts its multiple.
    assign mod_prod = PROD_W'(rem_reg) * PROD_W'(RECIP);
    assign mod_quo  = RAW_SET_W'(mod_prod >> RECIP_SH);
    assign mod_back = quo_reg * SETS_DIV;
    assign set_sel  = SETS_POW2 ? (rem_reg[SET_W-1:0] & SET_MASK) : rem_reg[SET_W-1:0];

    // Shared comparator and victim tracking for the way under test.
    assign way_hit   = valid_row_reg[way_reg] && (tag_rd_reg == tag_reg);
    assign way_last  = ((WCNT_W'(way_reg) + WCNT_W'(1)) == ways_eff);
    assign nru_here  = nru_row_reg[way_reg];
    assign vic_found = nru_found_reg | nru_here;
    assign vic_way   = nru_found_reg ? nru_way_reg : (nru_here ? way_reg : '0);

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
            ways_mask[i] = (WCNT_W'(i) < ways_eff);
    end

    assign res_onehot = MAX_WAYS'(1) << res_way_reg;
    assign nru_base   = (!res_hit_reg && refill_reg) ? (nru_row_reg | ways_mask) : nru_row_reg;
    assign nru_wb     = nru_base & ~res_onehot;
    assign valid_wb   = res_hit_reg ? valid_row_reg : (valid_row_reg | res_onehot);

    assign tag_rd_way = (state_reg == S_CMP) ? (way_reg + WAY_W'(1)) : '0;
    assign row_waddr  = clearing ? clr_reg : set_sel;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == SET_MASK || clr_reg == SET_W'(MAX_SETS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SPLIT;
            end
            S_SPLIT: state_next = SETS_POW2 ? S_ROW : S_MOD;
            S_MOD:
            begin
                if (!step_reg)
                    state_next = S_ROW;
            end
            S_ROW:   state_next = S_CMP;
            S_CMP:
            begin
                if (way_hit || way_last)
                    state_next = S_WB;
            end
            S_WB:
            begin
                if (wb_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready = 1'b0;
        clearing = 1'b0;
        wb_go    = 1'b0;
        case (state_reg)
            S_CLEAR: clearing = 1'b1;
            S_IDLE:  in_ready = 1'b1;
            S_WB:    wb_go    = !out_valid_reg || out_ready;
            default: ;
        endcase
        row_we = clearing || wb_go;
        tag_we = wb_go && !res_hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            step_reg      <= 1'b0;
            way_reg       <= '0;
            nru_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + SET_W'(1);
            if (state_reg == S_SPLIT)
                step_reg <= 1'b1;
            else if (state_reg == S_MOD)
                step_reg <= 1'b0;
            if (state_reg == S_ROW)
            begin
                way_reg       <= '0;
                nru_found_reg <= 1'b0;
            end
            else if (state_reg == S_CMP)
            begin
                way_reg <= way_reg + WAY_W'(1);
                if (nru_here)
                    nru_found_reg <= 1'b1;
            end
            if (wb_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            addr_reg <= address;
        if (state_reg == S_SPLIT)
        begin
            tag_reg <= tag_full[TAG_WIDTH-1:0];
            rem_reg <= raw_set;
        end
        else if (state_reg == S_MOD)
        begin
            if (step_reg)
                quo_reg <= mod_quo;
            else
                rem_reg <= rem_reg - mod_back;
        end
        if (state_reg == S_CMP)
        begin
            if (nru_here && !nru_found_reg)
                nru_way_reg <= way_reg;
            res_hit_reg <= way_hit;
            res_way_reg <= way_hit ? way_reg : vic_way;
            refill_reg  <= !vic_found;
        end
        if (wb_go)
        begin
            out_hit_reg <= res_hit_reg;
            out_way_reg <= res_way_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[{set_sel, res_way_reg}] <= tag_reg;
        tag_rd_reg <= tag_mem[{set_sel, tag_rd_way}];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            valid_mem[row_waddr] <= clearing ? '0 : valid_wb;
            nru_mem[row_waddr]   <= clearing ? '1 : nru_wb;
        end
        if (state_reg == S_ROW)
        begin
            valid_row_reg <= valid_mem[set_sel];
            nru_row_reg   <= nru_mem[set_sel];
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_hit      = out_hit_reg;
    assign out_way_ext = ADDR_W'(out_way_reg);
    assign way         = out_way_ext[OUT_WAY_W-1:0];

endmodule

// ===== sv/set_assoc_cache_nru_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_nru_lookup
// Set-associative cache tag store with not-recently-used replacement.
// ----------------------------------------------------------------------------
//  Channel   Signals                                 Beat
//  input     in_valid / in_ready, address            one reference address
//  output    out_valid / out_ready, is_hit, way      one hit or fill report
//  config    psel penable pwrite paddr pwdata ...    one register write
//
//  An item goes through the address split, the set row read, a compare of
//  each way in turn and the write-back. The ways compared are the way index
//  plus one on a hit, the ways in use on a miss; the single tag comparator
//  and the one-read-per-cycle tag memory take them in turn. If MAX_SETS is
//  not a power of two, a reciprocal-multiply set index reduction follows.
//  After reset a clearing pass over every set initializes the valid and
//  NRU rows; no item is accepted meanwhile, configuration writes are.
//  A stalled output holds the write-back until the result register drains.
// ----------------------------------------------------------------------------
module set_assoc_cache_nru_lookup
    import sacn_pkg::*;
#(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 256,
    parameter int TAG_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Reference channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_W-1:0]     address,
    // Result channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_hit,
    output logic [OUT_WAY_W-1:0]  way,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Live configuration shared with the lookup engine, which reads it directly.
    // The user must issue writes only while the engine is idle; not enforced.
    cfg_t cfg;

    sacn_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The engine splits the address, walks the ways of the selected set with
    // one comparator, and writes back the tag, valid and NRU state. Its result
    // register lets a new reference be taken while a report still waits.
    sacn_engine #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .address   (address),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_hit    (is_hit),
        .way       (way)
    );

endmodule

// ===== sv/sacn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacn_checker
// Port-level checks on reference and result beats of the lookup block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sacn_checker
    import sacn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 is_hit,
    input logic [OUT_WAY_W-1:0] way
);

    // Beats taken in but not yet reported.
    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end

    `SACN_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(is_hit) && $stable(way)), "result beat changed while stalled")
    `SACN_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "reference taken while busy")
    `SACN_ASSERT(a_no_orphan_result, out_valid |-> (pend_reg != 2'd0), "result with no reference")
    `SACN_ASSERT_ALWAYS(a_two_in_flight, (pend_reg == 2'd2) |-> (!in_ready && pend_reg != 2'd3), "too many beats in flight")

endmodule

bind set_assoc_cache_nru_lookup sacn_checker u_sacn_checker (.*);
